@@ hw/rtl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon fill test.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Edge queue between the front and the back part.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // Control flags that travel with every queued vertex.
  typedef struct packed {
    logic edge_a_vld;  // previous -> current edge exists
    logic edge_b_vld;  // closing edge current -> first exists
    logic query_last;  // emit a result after this item
    logic fill_rule;   // 0 nonzero, 1 even-odd
  } ctl_t;

  // Winding step of one edge.
  typedef struct packed {
    logic inc;
    logic dec;
  } step_t;

endpackage

@@ hw/rtl/pip_front.sv @@
// ----------------------------------------------------------------------------
// pip_front
// Accepts vertex items, tracks first/previous vertex of the open contour and
// forms the edge endpoints that the back part tests.
// ----------------------------------------------------------------------------
module pip_front #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_vld_i,
  output logic                         in_rdy_o,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         contour_last_i,
  input  logic                         query_last_i,
  input  logic                         fill_rule_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output pip_pkg::ctl_t                q_ctl_o,
  output logic signed [COORD_BITS-1:0] prev_x_o,
  output logic signed [COORD_BITS-1:0] prev_y_o,
  output logic signed [COORD_BITS-1:0] first_x_o,
  output logic signed [COORD_BITS-1:0] first_y_o
);
  import pip_pkg::*;

  logic signed [COORD_BITS-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic                         started_q, started_d;
  logic                         closing;

  assign in_rdy_o = !q_full_i;
  assign q_push_o = in_vld_i && !q_full_i;
  assign closing  = contour_last_i || query_last_i;

  // First vertex of a new contour is the current one.
  always_comb begin
    if (started_q) begin
      first_x_d = first_x_q;
      first_y_d = first_y_q;
    end else begin
      first_x_d = vertex_x_i;
      first_y_d = vertex_y_i;
    end
    started_d = !closing;
  end

  assign q_ctl_o.edge_a_vld = started_q;
  assign q_ctl_o.edge_b_vld = closing;
  assign q_ctl_o.query_last = query_last_i;
  assign q_ctl_o.fill_rule  = fill_rule_i;
  assign prev_x_o  = prev_x_q;
  assign prev_y_o  = prev_y_q;
  assign first_x_o = first_x_d;
  assign first_y_o = first_y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      started_q <= 1'b0;
    end else if (q_push_o) begin
      first_x_q <= first_x_d;
      first_y_q <= first_y_d;
      prev_x_q  <= vertex_x_i;
      prev_y_q  <= vertex_y_i;
      started_q <= started_d;
    end
  end

endmodule

@@ hw/rtl/pip_fifo.sv @@
// ----------------------------------------------------------------------------
// pip_fifo
// Short queue of edge jobs between the front and the back part.
// ----------------------------------------------------------------------------
module pip_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import pip_pkg::*;

  logic [WIDTH-1:0]   mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("fifo count beyond depth");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("fifo count missed a push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (wr_ptr_q == rd_ptr_q))
    else $error("fifo empty with pointer gap");

endmodule

@@ hw/rtl/pip_back.sv @@
// ----------------------------------------------------------------------------
// pip_back
// Edge crossing tests (both edges of each item), winding/parity accumulation and
// the result register.
// ----------------------------------------------------------------------------
module pip_back #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned WIND_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  output logic                         q_pop_o,
  input  pip_pkg::ctl_t                q_ctl_i,
  input  logic signed [COORD_BITS-1:0] q_px_i,
  input  logic signed [COORD_BITS-1:0] q_py_i,
  input  logic signed [COORD_BITS-1:0] q_vx_i,
  input  logic signed [COORD_BITS-1:0] q_vy_i,
  input  logic signed [COORD_BITS-1:0] q_prev_x_i,
  input  logic signed [COORD_BITS-1:0] q_prev_y_i,
  input  logic signed [COORD_BITS-1:0] q_first_x_i,
  input  logic signed [COORD_BITS-1:0] q_first_y_i,
  output logic                         out_vld_o,
  input  logic                         out_rdy_i,
  output logic                         inside_res_o,
  output logic signed [WIND_BITS-1:0]  winding_count_o,
  output logic                         crossing_parity_o
);
  import pip_pkg::*;

  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned DFW = PW + 1;
  localparam logic signed [WIND_BITS-1:0] WMax = {1'b0, {(WIND_BITS-1){1'b1}}};
  localparam logic signed [WIND_BITS-1:0] WMin = {1'b1, {(WIND_BITS-1){1'b0}}};

  function automatic logic signed [WIND_BITS-1:0] wind_step(
    input logic signed [WIND_BITS-1:0] acc,
    input step_t                       st
  );
    logic signed [WIND_BITS-1:0] r;
    r = acc;
    if (st.inc && acc != WMax) r = acc + 1'b1;
    if (st.dec && acc != WMin) r = acc - 1'b1;
    return r;
  endfunction

  // Whole pipe moves whenever the result register can take a new value.
  logic adv;
  assign adv     = !out_vld_o || out_rdy_i;
  assign q_pop_o = adv && !q_empty_i;

  // Edge 0: previous -> current, edge 1: current -> first (closing).
  logic signed [COORD_BITS-1:0] ax [2], ay [2], bx [2], by [2];
  logic                         evld [2];
  assign ax[0] = q_prev_x_i;  assign ay[0] = q_prev_y_i;
  assign bx[0] = q_vx_i;      assign by[0] = q_vy_i;
  assign ax[1] = q_vx_i;      assign ay[1] = q_vy_i;
  assign bx[1] = q_first_x_i; assign by[1] = q_first_y_i;
  assign evld[0] = q_ctl_i.edge_a_vld;
  assign evld[1] = q_ctl_i.edge_b_vld;

  // Stage registers
  logic                  s1_vld_q, s2_vld_q, s3_vld_q;
  ctl_t                  s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic signed [DW-1:0]  s1_dxb_q [2], s1_dyp_q [2], s1_dyb_q [2], s1_dxp_q [2];
  logic                  s1_up_q [2], s1_hit_q [2], s2_up_q [2], s2_hit_q [2];
  logic signed [PW-1:0]  s2_p_q [2], s2_q_q [2];
  step_t                 s3_st_q [2];

  for (genvar e = 0; e < 2; e++) begin : g_edge
    logic signed [DW-1:0]  axe, aye, bxe, bye, pxe, pye;
    logic                  up, hit;
    logic signed [DFW-1:0] dif;

    assign axe = {ax[e][COORD_BITS-1], ax[e]};
    assign aye = {ay[e][COORD_BITS-1], ay[e]};
    assign bxe = {bx[e][COORD_BITS-1], bx[e]};
    assign bye = {by[e][COORD_BITS-1], by[e]};
    assign pxe = {q_px_i[COORD_BITS-1], q_px_i};
    assign pye = {q_py_i[COORD_BITS-1], q_py_i};
    // Upward edge straddles py when by > py, downward when by <= py.
    assign up  = (ay[e] <= q_py_i);
    assign hit = evld[e] && (up ? (by[e] > q_py_i) : (by[e] <= q_py_i));
    // Cross product (b-a) x (p-a)
    assign dif = {s2_p_q[e][PW-1], s2_p_q[e]} - {s2_q_q[e][PW-1], s2_q_q[e]};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s1_dxb_q[e] <= bxe - axe;
        s1_dyp_q[e] <= pye - aye;
        s1_dyb_q[e] <= bye - aye;
        s1_dxp_q[e] <= pxe - axe;
        s1_up_q[e]  <= up;
        s1_hit_q[e] <= hit;
        s2_p_q[e]   <= s1_dxb_q[e] * s1_dyp_q[e];
        s2_q_q[e]   <= s1_dyb_q[e] * s1_dxp_q[e];
        s2_up_q[e]  <= s1_up_q[e];
        s2_hit_q[e] <= s1_hit_q[e];
        s3_st_q[e].inc <= s2_hit_q[e] && s2_up_q[e] && !dif[DFW-1] && (|dif);
        s3_st_q[e].dec <= s2_hit_q[e] && !s2_up_q[e] && dif[DFW-1];
      end
    end
  end

  // Accumulators
  logic signed [WIND_BITS-1:0] wind_q, wind_a, wind_b;
  logic                        par_q, par_b;

  assign wind_a = wind_step(wind_q, s3_st_q[0]);
  assign wind_b = wind_step(wind_a, s3_st_q[1]);
  assign par_b  = par_q ^ (s3_st_q[0].inc | s3_st_q[0].dec)
                        ^ (s3_st_q[1].inc | s3_st_q[1].dec);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctl_q <= q_ctl_i;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
    end
    if (adv && s3_vld_q && s3_ctl_q.query_last) begin
      winding_count_o   <= wind_b;
      crossing_parity_o <= par_b;
      inside_res_o      <= s3_ctl_q.fill_rule ? par_b : (wind_b != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_o <= 1'b0;
      wind_q    <= '0;
      par_q     <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= !q_empty_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_o <= s3_vld_q && s3_ctl_q.query_last;
      if (s3_vld_q) begin
        if (s3_ctl_q.query_last) begin
          wind_q <= '0;
          par_q  <= 1'b0;
        end else begin
          wind_q <= wind_b;
          par_q  <= par_b;
        end
      end
    end
  end

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s3_vld_q && s3_ctl_q.query_last) |=> (wind_q == '0 && !par_q))
    else $error("accumulators not cleared after result");
  a_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q |->
      (!(s3_st_q[0].inc && s3_st_q[0].dec) && !(s3_st_q[1].inc && s3_st_q[1].dec)))
    else $error("edge step both up and down");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(wind_q) && $stable(par_q)))
    else $error("accumulator moved while stalled");

endmodule

@@ hw/rtl/point_in_polygon_fill_test_core.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_fill_test_core
// Winding-number / even-odd point-in-polygon test over streamed contours.
// A query's result follows its last item through the edge queue, stages s1-s3 and the result register.
// Throughput: one item per cycle while the result port does not stall; both edges (incl. closing) tested per item.
// Stalls at the result port back up the 4-entry edge queue, then s_axis.
// Reset: asynchronous, clears contour tracking, queue, pipe and accumulators.
// ----------------------------------------------------------------------------
module point_in_polygon_fill_test_core #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned WIND_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input item stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [point_x | point_y | vertex_x | vertex_y] from bit 0 up, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // bit 0 contour_last, bit 1 fill_rule
  input  logic [1:0]                             s_axis_tuser,
  // query_last
  input  logic                                   s_axis_tlast,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [inside_res | winding_count | crossing_parity] from bit 0 up, zero pad
  output logic [((WIND_BITS+2+7)/8)*8-1:0]       m_axis_tdata
);
  import pip_pkg::*;

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned OUT_W  = ((WIND_BITS + 2 + 7) / 8) * 8;
  localparam int unsigned CTL_W  = $bits(ctl_t);
  localparam int unsigned ENT_W  = 8 * C + CTL_W;

  // Unpack the input item
  logic signed [C-1:0] point_x, point_y, vertex_x, vertex_y;
  assign point_x  = s_axis_tdata[C-1:0];
  assign point_y  = s_axis_tdata[2*C-1:C];
  assign vertex_x = s_axis_tdata[3*C-1:2*C];
  assign vertex_y = s_axis_tdata[4*C-1:3*C];

  // Front: contour tracking and edge formation
  logic                q_full, q_empty, q_push, q_pop;
  ctl_t                f_ctl;
  logic signed [C-1:0] f_prev_x, f_prev_y, f_first_x, f_first_y;

  pip_front #(.COORD_BITS(C)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_vld_i       (s_axis_tvalid),
    .in_rdy_o       (s_axis_tready),
    .vertex_x_i     (vertex_x),
    .vertex_y_i     (vertex_y),
    .contour_last_i (s_axis_tuser[0]),
    .query_last_i   (s_axis_tlast),
    .fill_rule_i    (s_axis_tuser[1]),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_ctl_o        (f_ctl),
    .prev_x_o       (f_prev_x),
    .prev_y_o       (f_prev_y),
    .first_x_o      (f_first_x),
    .first_y_o      (f_first_y)
  );

  // Edge queue: one entry per item, both edges' endpoints plus flags
  logic [ENT_W-1:0] q_wdata, q_rdata;
  assign q_wdata = {f_ctl, f_first_y, f_first_x, f_prev_y, f_prev_x,
                    vertex_y, vertex_x, point_y, point_x};

  pip_fifo #(.WIDTH(ENT_W)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ctl_t                b_ctl;
  logic signed [C-1:0] b_px, b_py, b_vx, b_vy, b_prev_x, b_prev_y, b_first_x, b_first_y;
  assign b_px      = q_rdata[C-1:0];
  assign b_py      = q_rdata[2*C-1:C];
  assign b_vx      = q_rdata[3*C-1:2*C];
  assign b_vy      = q_rdata[4*C-1:3*C];
  assign b_prev_x  = q_rdata[5*C-1:4*C];
  assign b_prev_y  = q_rdata[6*C-1:5*C];
  assign b_first_x = q_rdata[7*C-1:6*C];
  assign b_first_y = q_rdata[8*C-1:7*C];
  assign b_ctl     = q_rdata[ENT_W-1:8*C];

  // Back: crossing tests, accumulation, result register
  logic                        inside_res, crossing_parity;
  logic signed [WIND_BITS-1:0] winding_count;

  pip_back #(.COORD_BITS(C), .WIND_BITS(WIND_BITS)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_pop_o           (q_pop),
    .q_ctl_i           (b_ctl),
    .q_px_i            (b_px),
    .q_py_i            (b_py),
    .q_vx_i            (b_vx),
    .q_vy_i            (b_vy),
    .q_prev_x_i        (b_prev_x),
    .q_prev_y_i        (b_prev_y),
    .q_first_x_i       (b_first_x),
    .q_first_y_i       (b_first_y),
    .out_vld_o         (m_axis_tvalid),
    .out_rdy_i         (m_axis_tready),
    .inside_res_o      (inside_res),
    .winding_count_o   (winding_count),
    .crossing_parity_o (crossing_parity)
  );

  assign m_axis_tdata = OUT_W'({crossing_parity, winding_count, inside_res});

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for point_in_polygon_fill_test_core. Streams contour
// vertices with a query point and checks each inside / winding / parity
// result against a local winding-number tracker. Covers directed corner
// cases, zigzag runs that push the winding count up and down, and random
// queries. Random idle cycles are inserted on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CB = 24;  // coordinate width, Q16.8
  localparam int unsigned WB = 16;  // winding count width
  localparam int unsigned SD_W = ((4*CB+7)/8)*8;
  localparam int unsigned MD_W = ((WB+2+7)/8)*8;

  localparam int WIND_MAX = (1 << (WB-1)) - 1;
  localparam int WIND_MIN = -(1 << (WB-1));

  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};

  // Fill rule codes
  localparam bit RULE_NONZERO = 1'b0;
  localparam bit RULE_EVENODD = 1'b1;

  localparam int TOTAL_ITEMS   = 850;    // random queries fill up to this
  localparam int CLIMB_PAIRS   = 40;     // rungs per zigzag run
  localparam int DRAIN_CYCLES  = 16;     // extra wait after the last expected result
  localparam int CYCLE_LIMIT   = 2000000;

  // One input item: query point plus one contour vertex.
  typedef struct {
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic signed [CB-1:0] vx;
    logic signed [CB-1:0] vy;
    logic                 clast;
    logic                 qlast;
    logic                 rule;
  } vertex_item_t;

  // One result item.
  typedef struct {
    logic                 in_fill;
    logic signed [WB-1:0] count;
    logic                 parity;
  } fill_verdict_t;

  // --------------------------------------------------------------------------
  // Winding-number tracker: follows the open contour, tests every edge
  // (including the closing one) against the point of the completing item,
  // and queues the verdict of each finished query.
  // --------------------------------------------------------------------------
  class winding_tally;
    logic signed [CB-1:0] first_x, first_y, prev_x, prev_y;
    bit                   open_contour;
    int                   wind;
    bit                   parity;
    fill_verdict_t        pending_verdicts[$];
    int                   errors;

    function new();
      first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
      open_contour = 1'b0;
      wind = 0;
      parity = 1'b0;
      errors = 0;
    endfunction

    // Crossing test of edge a->b against a rightward ray from point p, exact cross product sign.
    function void cross_edge(longint ax, longint ay, longint bx, longint by,
                             longint px, longint py);
      longint cr;
      int     dir;
      cr  = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
      dir = 0;
      if (ay <= py) begin
        if (by > py && cr > 0) dir = 1;
      end else begin
        if (by <= py && cr < 0) dir = -1;
      end
      if (dir == 0) return;
      parity ^= 1'b1;
      if (dir > 0 && wind < WIND_MAX) wind++;
      if (dir < 0 && wind > WIND_MIN) wind--;
    endfunction

    function void note_vertex(vertex_item_t it);
      fill_verdict_t v;
      if (!open_contour) begin
        first_x = it.vx;
        first_y = it.vy;
        open_contour = 1'b1;
      end else begin
        cross_edge(prev_x, prev_y, it.vx, it.vy, it.px, it.py);
      end
      prev_x = it.vx;
      prev_y = it.vy;
      // query end closes the contour as well
      if (it.clast || it.qlast) begin
        cross_edge(it.vx, it.vy, first_x, first_y, it.px, it.py);
        open_contour = 1'b0;
      end
      if (it.qlast) begin
        v.in_fill = (it.rule == RULE_EVENODD) ? parity : (wind != 0);
        v.count   = wind[WB-1:0];
        v.parity  = parity;
        pending_verdicts.push_back(v);
        wind   = 0;
        parity = 1'b0;
      end
    endfunction

    function void check_verdict(logic [MD_W-1:0] data);
      fill_verdict_t got, want;
      got.in_fill = data[0];
      got.count   = data[WB:1];
      got.parity  = data[WB+1];
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result inside=%0b count=%0d parity=%0b",
                 $time, got.in_fill, got.count, got.parity);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.in_fill !== want.in_fill) begin
        $display("%0t: inside_res expected %0b, got %0b", $time, want.in_fill, got.in_fill);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: winding_count expected %0d, got %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.parity !== want.parity) begin
        $display("%0t: crossing_parity expected %0b, got %0b",
                 $time, want.parity, got.parity);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [SD_W-1:0] s_axis_tdata;  // point_x, point_y, vertex_x, vertex_y
  logic [1:0]      s_axis_tuser;  // contour_last, fill_rule
  logic            s_axis_tlast;  // query_last
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [MD_W-1:0] m_axis_tdata;  // inside_res, winding_count, crossing_parity

  winding_tally tally = new();
  int           items_sent;
  int           cycle_count;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  point_in_polygon_fill_test_core #(
    .COORD_BITS(CB),
    .WIND_BITS (WB)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Handshake monitor: results are checked before the same edge's item is
  // noted, so an unexpected result can never be hidden by a fresh query.
  always @(posedge clk_i) begin
    vertex_item_t it;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) tally.check_verdict(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        it.px    = s_axis_tdata[CB-1:0];
        it.py    = s_axis_tdata[2*CB-1:CB];
        it.vx    = s_axis_tdata[3*CB-1:2*CB];
        it.vy    = s_axis_tdata[4*CB-1:3*CB];
        it.clast = s_axis_tuser[0];
        it.rule  = s_axis_tuser[1];
        it.qlast = s_axis_tlast;
        tally.note_vertex(it);
      end
    end
  end

  // Result sink: random stall before each result, sometimes none.
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic vertex_item_t vertex_at(int px, int py, int vx, int vy,
                                             bit cl, bit ql, bit rule);
    vertex_item_t it;
    it.px = px[CB-1:0];
    it.py = py[CB-1:0];
    it.vx = vx[CB-1:0];
    it.vy = vy[CB-1:0];
    it.clast = cl;
    it.qlast = ql;
    it.rule  = rule;
    return it;
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Coordinate close to c, now and then C_MIN or C_MAX; negative spread means anywhere. Wraps at CB bits.
  function automatic logic signed [CB-1:0] coord_near(logic signed [CB-1:0] c,
                                                      int spread);
    int off;
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return C_MIN;
    if (pick == 1) return C_MAX;
    if (spread < 0) return CB'($urandom);
    off = int'($urandom_range(0, 2*spread)) - spread;
    return CB'(c + off);
  endfunction

  function automatic logic signed [CB-1:0] query_coord();
    case ($urandom_range(0, 7))
      0:       return C_MIN;
      1:       return C_MAX;
      2, 3:    return CB'($urandom);
      default: return CB'(int'($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  task automatic push_vertex(vertex_item_t it, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.vy, it.vx, it.py, it.px};
    s_axis_tuser  <= {it.rule, it.clast};
    s_axis_tlast  <= it.qlast;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Vertical zigzag at x=1.0. Active point (0,0) makes an edge count,
  // the neutral point (0,4.0) lies above every edge. Rising runs the count
  // up, falling runs it down; the last two rungs step both ways.
  task automatic climb(int pairs, bit rising, bit rule);
    int k;
    bit up_on, down_on;
    push_vertex(vertex_at(0, 1024, 256, -256, 1'b0, 1'b0, rule), 0);
    for (k = 0; k < pairs; k++) begin
      up_on   = rising || (k >= pairs - 2);
      down_on = !rising || (k >= pairs - 2);
      push_vertex(vertex_at(0, up_on ? 0 : 1024, 256, 256, 1'b0, 1'b0, rule), 0);
      push_vertex(vertex_at(0, down_on ? 0 : 1024, 256, -256, 1'b0,
                            k == pairs - 1, rule), 0);
    end
  endtask

  task automatic directed_queries();
    // single item query: no real edge, reports outside
    push_vertex(vertex_at(0, 0, 100, 100, 1'b0, 1'b1, RULE_NONZERO), draw_gap(0));
    // CCW square of side 2.0 around the origin, nonzero
    push_vertex(vertex_at(0, 0, -256, -256, 1'b0, 1'b0, RULE_EVENODD), draw_gap(0));
    push_vertex(vertex_at(0, 0,  256, -256, 1'b0, 1'b0, RULE_EVENODD), draw_gap(0));
    push_vertex(vertex_at(0, 0,  256,  256, 1'b0, 1'b0, RULE_EVENODD), draw_gap(0));
    push_vertex(vertex_at(0, 0, -256,  256, 1'b1, 1'b1, RULE_NONZERO), draw_gap(0));
    // CW square, point on the right edge, only the last item's rule counts
    push_vertex(vertex_at(256, 0, -256,  256, 1'b0, 1'b0, RULE_NONZERO), draw_gap(0));
    push_vertex(vertex_at(256, 0,  256,  256, 1'b0, 1'b0, RULE_NONZERO), draw_gap(0));
    push_vertex(vertex_at(256, 0,  256, -256, 1'b0, 1'b0, RULE_NONZERO), draw_gap(0));
    push_vertex(vertex_at(256, 0, -256, -256, 1'b1, 1'b1, RULE_EVENODD), draw_gap(0));
    // full-range triangle, point at the origin
    push_vertex(vertex_at(0, 0, C_MIN, C_MIN, 1'b0, 1'b0, RULE_EVENODD), draw_gap(0));
    push_vertex(vertex_at(0, 0, C_MAX, C_MIN, 1'b0, 1'b0, RULE_EVENODD), draw_gap(0));
    push_vertex(vertex_at(0, 0, 0, C_MAX, 1'b1, 1'b1, RULE_EVENODD), draw_gap(0));
    // same triangle, point at the extreme corners
    push_vertex(vertex_at(C_MAX, C_MAX, C_MIN, C_MIN, 1'b0, 1'b0, RULE_NONZERO),
                draw_gap(0));
    push_vertex(vertex_at(C_MIN, C_MIN, C_MAX, C_MIN, 1'b0, 1'b0, RULE_NONZERO),
                draw_gap(0));
    push_vertex(vertex_at(C_MIN, C_MAX, 0, C_MAX, 1'b1, 1'b1, RULE_NONZERO), draw_gap(0));
    // single-vertex contour, then a triangle closed only by the query end
    push_vertex(vertex_at(0, 0, 5, 5, 1'b1, 1'b0, RULE_NONZERO), draw_gap(0));
    push_vertex(vertex_at(0, 0, -512, -256, 1'b0, 1'b0, RULE_NONZERO), draw_gap(0));
    push_vertex(vertex_at(0, 0,  512, -256, 1'b0, 1'b0, RULE_NONZERO), draw_gap(0));
    push_vertex(vertex_at(0, 0, 0, 512, 1'b0, 1'b1, RULE_NONZERO), draw_gap(0));
    // point moves between items of one query
    push_vertex(vertex_at(0, 0, -256, -256, 1'b0, 1'b0, RULE_NONZERO), draw_gap(0));
    push_vertex(vertex_at(-512, 0, 256, -256, 1'b0, 1'b0, RULE_NONZERO), draw_gap(0));
    push_vertex(vertex_at(0, 0, 256, 256, 1'b0, 1'b0, RULE_NONZERO), draw_gap(0));
    push_vertex(vertex_at(512, 0, -256, 256, 1'b1, 1'b1, RULE_EVENODD), draw_gap(0));
  endtask

  // Mostly well-formed queries near the point (so edges straddle it), some
  // with a moving point or a query end that closes the contour, and a few
  // with fully random fields.
  task automatic random_queries(int quota);
    vertex_item_t         it;
    int                   contours, nv, c, v, spread;
    bit                   calm;
    logic signed [CB-1:0] qx, qy;
    while (items_sent < quota) begin
      calm = ($urandom_range(0, 3) == 0);
      qx = query_coord();
      qy = query_coord();
      case ($urandom_range(0, 3))
        0:       spread = 2;
        1:       spread = 40;
        2:       spread = 3000;
        default: spread = -1;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        do begin
          it.px    = CB'($urandom);
          it.py    = CB'($urandom);
          it.vx    = CB'($urandom);
          it.vy    = CB'($urandom);
          it.clast = 1'($urandom_range(0, 1));
          it.qlast = ($urandom_range(0, 5) == 0);
          it.rule  = 1'($urandom_range(0, 1));
          push_vertex(it, draw_gap(calm));
        end while (!it.qlast);
      end else begin
        contours = $urandom_range(1, 4);
        for (c = 0; c < contours; c++) begin
          nv = $urandom_range(1, 6);
          for (v = 0; v < nv; v++) begin
            if ($urandom_range(0, 7) == 0) begin
              qx = coord_near(qx, spread);
              qy = coord_near(qy, spread);
            end
            it.px    = qx;
            it.py    = qy;
            it.vx    = coord_near(qx, spread);
            it.vy    = coord_near(qy, spread);
            it.clast = (v == nv - 1);
            it.qlast = (c == contours - 1) && (v == nv - 1);
            if (it.qlast && $urandom_range(0, 4) == 0) it.clast = 1'b0;
            it.rule  = 1'($urandom_range(0, 1));
            push_vertex(it, draw_gap(calm));
          end
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    items_sent    = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_queries();
    climb(CLIMB_PAIRS, 1'b1, RULE_NONZERO);
    climb(CLIMB_PAIRS, 1'b0, RULE_EVENODD);
    random_queries(TOTAL_ITEMS);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tally.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tally.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
